>>> src/device_liveness_table_assert.svh
// Assertion macros for the device liveness table.
// Included by the top level; no other dependencies.
`ifndef DEVICE_LIVENESS_TABLE_ASSERT_SVH
`define DEVICE_LIVENESS_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DLT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define DLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define DLT_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define DLT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/dlt_pkg.sv
// Shared types and constants for the device liveness table.
// No dependencies.
package dlt_pkg;
  localparam int ENTRIES = 64;
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int OUT_CNT_W = 7;

  localparam logic [2:0] OP_REPORT = 3'd0;
  localparam logic [2:0] OP_BAD    = 3'd1;
  localparam logic [2:0] OP_TOUCH  = 3'd2;
  localparam logic [2:0] OP_SWEEP  = 3'd3;

  localparam logic [2:0] ST_FOUND    = 3'd0;
  localparam logic [2:0] ST_CREATED  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_SWEPT    = 3'd4;

  localparam int REC_W = 1 + 32 + 32 + 16 + 16 + 32 + 32 + 32 + 32;

  typedef struct packed {
    logic        online;
    logic [31:0] key;
    logic [31:0] session;
    logic [31:0] sequence_v;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [31:0] seen;
    logic [31:0] good;
    logic [31:0] bad;
  } rec_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] device_id;
    logic [31:0] session;
    logic [31:0] sequence_req;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [31:0] now_seconds;
  } req_t;

  // Controller to datapath.
  typedef struct packed {
    logic             capture;   // latch the request
    logic             rd_en;     // read slot at scan_idx
    logic [IDX_W-1:0] scan_idx;
    logic             eval;      // rd_data valid for the slot latched in eidx_r
    logic             commit;    // apply operation to chosen slot
    logic             sweep_wr;  // write back sweep result
    logic             result;    // raise the output valid flag
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic       is_sweep;
  } dp_sts_t;
endpackage

>>> src/dlt_if.sv
// Valid/ready channel interface carrying one payload type.
// Depends on dlt_pkg only through the payload type parameter.
interface dlt_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> src/dlt_ram.sv
// Generic RAM with one write port and one registered read port.
// No dependencies.
module dlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> src/dlt_ctrl.sv
// Controller FSM: walks every slot for lookup and sweep, then commits.
// Depends on dlt_pkg.
module dlt_ctrl
  import dlt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    res_busy,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             ev_r, ev_nxt;

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    ev_nxt = 1'b0;
    cmd = '0;
    cmd.scan_idx = idx_r;
    in_ready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_nxt = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        // Slot read issued now, evaluated in the next cycle.
        cmd.rd_en = 1'b1;
        ev_nxt = 1'b1;
        if (idx_r == IDX_W'(ENTRIES - 1)) state_nxt = S_LAST;
        else idx_nxt = idx_r + 1'b1;
      end
      S_LAST: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!res_busy) begin
          cmd.commit = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.result = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    cmd.eval = ev_r;
    cmd.sweep_wr = ev_r & sts.is_sweep;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r <= '0;
      ev_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r <= idx_nxt;
      ev_r <= ev_nxt;
    end
  end
endmodule

>>> src/dlt_dp.sv
// Datapath: record memory, valid bits, search results, update and output.
// Depends on dlt_pkg and dlt_ram.
module dlt_dp
  import dlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  req_t        req,
  input  dp_cmd_t     cmd,
  input  logic [15:0] timeout,
  output dp_sts_t     sts,
  output logic [2:0]  o_status,
  output rec_t        o_rec,
  output logic [6:0]  o_known
);
  logic [ENTRIES-1:0] valid_r;
  logic [CNT_W-1:0]   total_r;
  req_t               req_r;
  logic [IDX_W-1:0]   eidx_r;
  logic               hit_r, free_r;
  logic [IDX_W-1:0]   hit_idx_r, free_idx_r;
  rec_t               hit_rec_r;
  rec_t               rd_rec, wr_rec;
  logic [REC_W-1:0]   rd_raw;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [2:0]         status_r;
  rec_t               res_rec_r;
  logic [IDX_W-1:0]   raddr;

  assign raddr = cmd.scan_idx;
  assign rd_rec = rec_t'(rd_raw);

  dlt_ram #(.WIDTH(REC_W), .DEPTH(ENTRIES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wr_rec),
    .re(cmd.rd_en), .raddr(raddr), .rdata(rd_raw)
  );

  logic is_sweep, is_query;
  assign is_query = req_r.op[2];
  assign is_sweep = (req_r.op == OP_SWEEP);
  assign sts.is_sweep = is_sweep;

  // Sweep age test on the slot just read.
  logic [31:0] age;
  logic        stale;
  rec_t        swept;
  assign age = req_r.now_seconds - rd_rec.seen;
  assign stale = valid_r[eidx_r] && !age[31] && (age > {16'd0, timeout});
  always_comb begin
    swept = rd_rec;
    swept.online = 1'b0;
  end

  // Commit update.
  logic        do_make, do_upd;
  rec_t        base, upd;
  logic [2:0]  st;
  logic [IDX_W-1:0] slot;
  always_comb begin
    do_make = 1'b0;
    do_upd = 1'b0;
    slot = hit_idx_r;
    base = hit_rec_r;
    st = ST_NOTFOUND;
    if (is_query) begin
      st = hit_r ? ST_FOUND : ST_NOTFOUND;
    end else if (req_r.op == OP_BAD) begin
      st = hit_r ? ST_FOUND : ST_NOTFOUND;
      do_upd = hit_r;
    end else if (is_sweep) begin
      st = ST_SWEPT;
    end else if (hit_r) begin
      st = ST_FOUND;
      do_upd = 1'b1;
    end else if (free_r) begin
      st = ST_CREATED;
      do_upd = 1'b1;
      do_make = 1'b1;
      slot = free_idx_r;
      base = '0;
      base.online = 1'b1;
      base.key = req_r.device_id;
      base.session = (req_r.op == OP_REPORT) ? req_r.session : 32'd0;
    end else begin
      st = ST_FULL;
    end
    upd = base;
    case (req_r.op)
      OP_REPORT: begin
        upd.sequence_v = req_r.sequence_req;
        upd.temperature = req_r.temperature;
        upd.humidity = req_r.humidity;
        upd.seen = req_r.now_seconds;
        upd.online = 1'b1;
        if (~&base.good) upd.good = base.good + 32'd1;
      end
      OP_BAD: begin
        if (~&base.bad) upd.bad = base.bad + 32'd1;
      end
      OP_TOUCH: begin
        upd.seen = req_r.now_seconds;
        upd.online = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = slot;
    wr_rec = upd;
    if (cmd.sweep_wr) begin
      we = stale;
      waddr = eidx_r;
      wr_rec = swept;
    end else if (cmd.commit) begin
      we = do_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) req_r <= req;
    eidx_r <= cmd.scan_idx;
    if (cmd.eval && !hit_r && valid_r[eidx_r] && rd_rec.key == req_r.device_id) begin
      hit_idx_r <= eidx_r;
      hit_rec_r <= rd_rec;
    end
    if (cmd.eval && !free_r && !valid_r[eidx_r]) free_idx_r <= eidx_r;
    if (cmd.commit) begin
      status_r <= st;
      res_rec_r <= (do_upd || (is_query && hit_r)) ? upd : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      hit_r <= 1'b0;
      free_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        hit_r <= 1'b0;
        free_r <= 1'b0;
      end else if (cmd.eval) begin
        if (valid_r[eidx_r] && rd_rec.key == req_r.device_id) hit_r <= 1'b1;
        if (!valid_r[eidx_r]) free_r <= 1'b1;
      end
      if (cmd.commit && do_make) begin
        valid_r[slot] <= 1'b1;
        total_r <= total_r + 1'b1;
      end
    end
  end

  assign o_status = status_r;
  assign o_rec = res_rec_r;
  assign o_known = 7'(total_r);
endmodule

>>> src/device_liveness_table.sv
// Device liveness table: up to ENTRIES device records keyed by a 32-bit id.
// Every item walks all slots of the record memory (one write port, one read
// port), one slot per cycle, then commits at most one write. A new item is
// accepted only when the previous one has finished its scan, commit and
// result load. A result still waiting delays only the commit of the
// following item. A sweep writes back stale slots during the same scan.
// Valid bits live in flip-flops and clear at reset.
`include "device_liveness_table_assert.svh"
module device_liveness_table
  import dlt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_device_id,
  input  logic [31:0] in_session,
  input  logic [31:0] in_sequence_req,
  input  logic signed [15:0] in_temperature,
  input  logic signed [15:0] in_humidity,
  input  logic [31:0] in_now_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_is_online,
  output logic [31:0] out_owner_session,
  output logic [31:0] out_stored_sequence,
  output logic signed [15:0] out_stored_temperature,
  output logic signed [15:0] out_stored_humidity,
  output logic [31:0] out_seen_time,
  output logic [31:0] out_good_count,
  output logic [31:0] out_bad_count,
  output logic [6:0]  out_devices_known,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_timeout_seconds
);
  dlt_if #(.T(req_t)) in_ch ();
  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic [15:0] timeout_r;
  logic        out_valid_r;
  logic [2:0]  st;
  rec_t        rec;
  logic [6:0]  known;
  req_t        req;

  assign in_ch.valid = in_valid;
  assign in_ch.data = '{in_op, in_device_id, in_session, in_sequence_req,
                        in_temperature, in_humidity, in_now_seconds};
  assign in_ready = in_ch.ready;
  assign req = in_ch.data;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) timeout_r <= 16'd30;
    else if (cfg_valid) timeout_r <= cfg_timeout_seconds;
  end

  dlt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .res_busy(out_valid_r), .sts(sts), .cmd(cmd)
  );

  dlt_dp u_dp (
    .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .timeout(timeout_r),
    .sts(sts), .o_status(st), .o_rec(rec), .o_known(known)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.result) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  assign out_valid = out_valid_r;
  assign out_status = st;
  assign out_is_online = rec.online;
  assign out_owner_session = rec.session;
  assign out_stored_sequence = rec.sequence_v;
  assign out_stored_temperature = rec.temperature;
  assign out_stored_humidity = rec.humidity;
  assign out_seen_time = rec.seen;
  assign out_good_count = rec.good;
  assign out_bad_count = rec.bad;
  assign out_devices_known = known;

  `DLT_ASSERT_NEXT(a_result_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `DLT_ASSERT_IMPL(a_no_result_clash, clk, rst_n, cmd.result, !out_valid)
  `DLT_ASSERT_IMPL(a_known_range, clk, rst_n, 1'b1, out_devices_known <= 7'(ENTRIES))
endmodule

>>> test/device_liveness_table_test.sv
// Self-checking testbench for device_liveness_table: report, bad, touch, sweep and query
// items against a behavioral table model, with random idling and output back-pressure.
// Depends on dlt_pkg, dlt_if and the device_liveness_table RTL.
module device_liveness_table_test;
  import dlt_pkg::*;

  localparam logic [2:0] OP_QUERY = 3'd4;
  localparam int SLOTS = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_OFF_CYCLES = 300;

  typedef struct packed {
    logic [2:0]  status;
    logic        online;
    logic [31:0] session;
    logic [31:0] sequence_v;
    logic [15:0] temperature;
    logic [15:0] humidity;
    logic [31:0] seen;
    logic [31:0] good;
    logic [31:0] bad;
    logic [6:0]  known;
  } status_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dlt_if #(.T(req_t))        in_ch ();
  dlt_if #(.T(status_rec_t)) out_ch ();
  dlt_if #(.T(logic [15:0])) cfg_ch ();

  device_liveness_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_op(in_ch.data.op), .in_device_id(in_ch.data.device_id),
    .in_session(in_ch.data.session), .in_sequence_req(in_ch.data.sequence_req),
    .in_temperature(in_ch.data.temperature), .in_humidity(in_ch.data.humidity),
    .in_now_seconds(in_ch.data.now_seconds),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_status(out_ch.data.status), .out_is_online(out_ch.data.online),
    .out_owner_session(out_ch.data.session),
    .out_stored_sequence(out_ch.data.sequence_v),
    .out_stored_temperature(out_ch.data.temperature),
    .out_stored_humidity(out_ch.data.humidity),
    .out_seen_time(out_ch.data.seen), .out_good_count(out_ch.data.good),
    .out_bad_count(out_ch.data.bad), .out_devices_known(out_ch.data.known),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_timeout_seconds(cfg_ch.data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Table model state.
  bit          tbl_valid [SLOTS];
  logic [31:0] tbl_key [SLOTS];
  logic [31:0] tbl_session [SLOTS];
  logic [31:0] tbl_sequence [SLOTS];
  logic [15:0] tbl_temp [SLOTS];
  logic [15:0] tbl_hum [SLOTS];
  logic [31:0] tbl_seen [SLOTS];
  bit          tbl_online [SLOTS];
  logic [31:0] tbl_good [SLOTS];
  logic [31:0] tbl_bad [SLOTS];
  int unsigned tbl_used;
  logic [15:0] timeout_setting;

  status_rec_t pending_status[$];
  int unsigned fail_count, items_sent, results_seen, sweeps_sent, full_seen;
  int unsigned cycle_count;
  bit idling_on;
  bit hold_request;
  logic [31:0] clock_now;
  logic [31:0] key_pool[$];

  function automatic int find_slot(logic [31:0] key);
    for (int i = 0; i < SLOTS; i++)
      if (tbl_valid[i] && tbl_key[i] == key) return i;
    return -1;
  endfunction

  function automatic int find_or_create(logic [31:0] key, logic [31:0] sess,
                                        output logic [2:0] st);
    int s;
    s = find_slot(key);
    if (s >= 0) begin
      st = ST_FOUND;
      return s;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (!tbl_valid[i]) begin
        tbl_valid[i] = 1'b1;
        tbl_key[i] = key;
        tbl_session[i] = sess;
        tbl_sequence[i] = '0;
        tbl_temp[i] = '0;
        tbl_hum[i] = '0;
        tbl_seen[i] = '0;
        tbl_online[i] = 1'b1;
        tbl_good[i] = '0;
        tbl_bad[i] = '0;
        tbl_used++;
        st = ST_CREATED;
        return i;
      end
    end
    st = ST_FULL;
    return -1;
  endfunction

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic status_rec_t apply_item(req_t r);
    status_rec_t res;
    logic [2:0] st;
    logic [31:0] age;
    int s;
    st = ST_NOTFOUND;
    s = -1;
    if (r.op[2]) begin
      s = find_slot(r.device_id);
      st = (s >= 0) ? ST_FOUND : ST_NOTFOUND;
    end else if (r.op == OP_REPORT) begin
      s = find_or_create(r.device_id, r.session, st);
      if (s >= 0) begin
        tbl_sequence[s] = r.sequence_req;
        tbl_temp[s] = r.temperature;
        tbl_hum[s] = r.humidity;
        tbl_seen[s] = r.now_seconds;
        tbl_online[s] = 1'b1;
        tbl_good[s] = bump(tbl_good[s]);
      end
    end else if (r.op == OP_BAD) begin
      s = find_slot(r.device_id);
      if (s >= 0) begin
        st = ST_FOUND;
        tbl_bad[s] = bump(tbl_bad[s]);
      end
    end else if (r.op == OP_TOUCH) begin
      s = find_or_create(r.device_id, 32'd0, st);
      if (s >= 0) begin
        tbl_seen[s] = r.now_seconds;
        tbl_online[s] = 1'b1;
      end
    end else begin
      // Ages that look negative as signed values never expire a device.
      for (int i = 0; i < SLOTS; i++) begin
        if (tbl_valid[i]) begin
          age = r.now_seconds - tbl_seen[i];
          if (!age[31] && age > {16'd0, timeout_setting}) tbl_online[i] = 1'b0;
        end
      end
      st = ST_SWEPT;
    end
    res = '0;
    res.status = st;
    if (s >= 0) begin
      res.online = tbl_online[s];
      res.session = tbl_session[s];
      res.sequence_v = tbl_sequence[s];
      res.temperature = tbl_temp[s];
      res.humidity = tbl_hum[s];
      res.seen = tbl_seen[s];
      res.good = tbl_good[s];
      res.bad = tbl_bad[s];
    end
    res.known = tbl_used[6:0];
    return res;
  endfunction

  // Drives one item and holds it until accepted; valid stays high afterwards
  // unless an idle burst follows, so back-to-back items never glitch valid.
  task automatic send_item(req_t r);
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pending_status.push_back(apply_item(r));
    items_sent++;
    if (r.op == OP_SWEEP) sweeps_sent++;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  function automatic req_t build_item(logic [2:0] op, logic [31:0] key, logic [31:0] now);
    req_t r;
    r.op = op;
    r.device_id = key;
    r.session = $urandom;
    r.sequence_req = $urandom;
    r.temperature = $urandom;
    r.humidity = $urandom;
    r.now_seconds = now;
    return r;
  endfunction

  function automatic req_t random_item();
    logic [2:0] op;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) op = OP_REPORT;
    else if (pick < 50) op = OP_BAD;
    else if (pick < 65) op = OP_TOUCH;
    else if (pick < 80) op = OP_SWEEP;
    else op = 3'($urandom_range(4, 7));
    if ($urandom_range(0, 9) == 0) clock_now = $urandom;
    else clock_now += $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0)
      return build_item(op, $urandom, clock_now);
    return build_item(op, key_pool[$urandom_range(0, key_pool.size() - 1)], clock_now);
  endfunction

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_status.size() != 0) @(posedge clk);
    // A quiet gap before configuration or the end of the run.
    repeat (80) @(posedge clk);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    timeout_setting = value;
  endtask

  task automatic test_directed();
    send_item(build_item(OP_QUERY, 32'h0, 32'd0));
    send_item(build_item(OP_BAD, 32'h0, 32'd0));
    send_item(build_item(OP_SWEEP, 32'h0, 32'd0));
    send_item('{OP_REPORT, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h7FFF, 32'd0});
    send_item('{OP_REPORT, 32'h0, 32'h0, 32'h0, 16'h7FFF, 16'h8000, 32'd100});
    send_item(build_item(OP_TOUCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_item(build_item(OP_TOUCH, 32'hFFFF_FFFF, 32'd130));
    send_item(build_item(OP_BAD, 32'h0, 32'd0));
    send_item(build_item(OP_BAD, 32'h1234_5678, 32'd0));
    send_item(build_item(OP_QUERY, 32'hFFFF_FFFF, 32'd0));
    send_item(build_item(3'd5, 32'h0, 32'd0));
    send_item(build_item(3'd6, 32'hFFFF_FFFF, 32'd0));
    send_item(build_item(3'd7, 32'h5555_AAAA, 32'd0));
    // A device seen far in the future looks negative in age and stays online.
    send_item(build_item(OP_REPORT, 32'hAAAA_5555, 32'h7000_0000));
    // Age equal to the timeout keeps device 0, age beyond it expires it.
    send_item(build_item(OP_SWEEP, 32'h0, 32'd130));
    send_item(build_item(OP_QUERY, 32'h0, 32'd0));
    send_item(build_item(OP_SWEEP, 32'h0, 32'd131));
    send_item(build_item(OP_QUERY, 32'h0, 32'd0));
    send_item(build_item(OP_QUERY, 32'hAAAA_5555, 32'd0));
    send_item(build_item(OP_TOUCH, 32'h0, 32'd200));
  endtask

  task automatic test_random(int count);
    repeat (count) send_item(random_item());
  endtask

  task automatic test_timeout_settings();
    logic [15:0] values [3];
    values = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 200))};
    foreach (values[i]) begin
      write_timeout(values[i]);
      test_random(150);
    end
    write_timeout(16'd30);
  endtask

  task automatic test_back_pressure();
    hold_request = 1'b1;
    repeat (8) send_item(random_item());
  endtask

  task automatic test_full_table();
    while (tbl_used < SLOTS) begin
      clock_now += 1;
      send_item(build_item($urandom_range(0, 1) ? OP_REPORT : OP_TOUCH, $urandom, clock_now));
    end
    repeat (30) begin
      clock_now += 1;
      send_item(build_item($urandom_range(0, 1) ? OP_REPORT : OP_TOUCH, $urandom, clock_now));
    end
    for (int i = 0; i < 10; i++)
      send_item(build_item(OP_QUERY, tbl_key[$urandom_range(0, SLOTS - 1)], clock_now));
  endtask

  always @(posedge clk) begin
    status_rec_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        $error("result with no item outstanding: status %0d", out_ch.data.status);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        if (want.status == ST_FULL) full_seen++;
        if (out_ch.data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_ch.data.status);
          fail_count++;
        end
        if (out_ch.data.online !== want.online) begin
          $error("is_online: expected %0d, got %0d", want.online, out_ch.data.online);
          fail_count++;
        end
        if (out_ch.data.session !== want.session) begin
          $error("owner_session: expected %h, got %h", want.session, out_ch.data.session);
          fail_count++;
        end
        if (out_ch.data.sequence_v !== want.sequence_v) begin
          $error("stored_sequence: expected %h, got %h", want.sequence_v,
                 out_ch.data.sequence_v);
          fail_count++;
        end
        if (out_ch.data.temperature !== want.temperature) begin
          $error("stored_temperature: expected %h, got %h", want.temperature,
                 out_ch.data.temperature);
          fail_count++;
        end
        if (out_ch.data.humidity !== want.humidity) begin
          $error("stored_humidity: expected %h, got %h", want.humidity, out_ch.data.humidity);
          fail_count++;
        end
        if (out_ch.data.seen !== want.seen) begin
          $error("seen_time: expected %h, got %h", want.seen, out_ch.data.seen);
          fail_count++;
        end
        if (out_ch.data.good !== want.good) begin
          $error("good_count: expected %0d, got %0d", want.good, out_ch.data.good);
          fail_count++;
        end
        if (out_ch.data.bad !== want.bad) begin
          $error("bad_count: expected %0d, got %0d", want.bad, out_ch.data.bad);
          fail_count++;
        end
        if (out_ch.data.known !== want.known) begin
          $error("devices_known: expected %0d, got %0d", want.known, out_ch.data.known);
          fail_count++;
        end
      end
    end
  end

  // Result side: ready with random stall bursts, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    tbl_used = 0;
    timeout_setting = 16'd30;
    idling_on = 1'b1;
    hold_request = 1'b0;
    clock_now = 32'd1000;
    key_pool.push_back(32'h0);
    key_pool.push_back(32'hFFFF_FFFF);
    repeat (40) key_pool.push_back($urandom);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(350);
    test_timeout_settings();
    test_back_pressure();
    test_random(350);
    test_full_table();
    test_random(250);
    idling_on = 1'b0;
    test_random(200);

    wait_idle();
    $display("Sent %0d items (%0d sweeps), checked %0d results, %0d with a full table.",
             items_sent, sweeps_sent, results_seen, full_seen);
    $display("Timeouts 0, 30, 65535 and a random value were used; %0d mismatches.",
             fail_count);
    if (fail_count == 0 && pending_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/dlt_pkg.sv
src/dlt_if.sv
src/dlt_ram.sv
src/dlt_ctrl.sv
src/dlt_dp.sv
src/device_liveness_table.sv
test/device_liveness_table_test.sv
